// ===== src/servo_status_frame_parser_macros.svh =====
// Assertion helpers for the checker file.
`ifndef SERVO_STATUS_FRAME_PARSER_MACROS_SVH
`define SERVO_STATUS_FRAME_PARSER_MACROS_SVH

// Check an implication in the same cycle, clocked on clk, off during reset.
`define SSFP_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check an implication in the next cycle.
`define SSFP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/ssfp_pkg.sv =====
`timescale 1ns / 1ps

package ssfp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] MIN_LEN  = 8'd2;

  localparam logic [1:0] ST_GOOD  = 2'd0;
  localparam logic [1:0] ST_CSUM  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HDR,
    PH_LEN,
    PH_ERR,
    PH_PARAM,
    PH_CHK,
    PH_CHK_SHORT
  } phase_t;

  // Packed so that servo_id lands in the lowest bits.
  typedef struct packed {
    logic [1:0] frame_status;
    logic [7:0] param_index;
    logic [7:0] data_byte;
    logic [7:0] error_bits;
    logic [7:0] servo_id;
  } result_t;

  typedef struct packed {
    logic    last;
    result_t res;
  } result_beat_t;

endpackage

// ===== src/servo_status_frame_parser.sv =====
// Servo status frame parser: one received byte per beat in, one result per parameter
// or checksum byte out. Each byte passes the input register, then the result register.
// Throughput is one byte per cycle while out_tready does not stall the result register,
// set by the combinational phase update between the two registers.
// rst_n is synchronous, active low: clears the valid flags of both registers and returns to hunting.
`timescale 1ns / 1ps

module servo_status_frame_parser import ssfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] servo_id, [15:8] error_bits, [23:16] data_byte,
                                  // [31:24] param_index, [33:32] frame_status, rest zero
  output logic        out_tlast   // last: closing beat of a frame
);

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         take;
  logic         can_take;
  logic         res_valid;
  result_beat_t res_beat;

  // Capture the incoming beat; advance it when the parser takes it.
  ssfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Hunt for the header, walk the frame fields, check the checksum.
  // A byte is consumed only when the result register has room, so the
  // frame state never runs ahead of the output.
  ssfp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .out_ready  (can_take),
    .take       (take),
    .res_valid  (res_valid),
    .res_beat   (res_beat)
  );

  // Hold the result beat until the sink takes it.
  ssfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_beat   (res_beat),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/ssfp_in_reg.sv =====
`timescale 1ns / 1ps

module ssfp_in_reg import ssfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

// ===== src/ssfp_parse.sv =====
`timescale 1ns / 1ps

module ssfp_parse import ssfp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_valid,
  input  logic [7:0]   byte_data,
  input  logic         out_ready,
  output logic         take,
  output logic         res_valid,
  output result_beat_t res_beat
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] err_r, err_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       short_r, short_nxt;
  logic [7:0] left_dec;

  assign take     = byte_valid && out_ready;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    err_nxt   = err_r;
    left_nxt  = left_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    short_nxt = short_r;
    res_valid = 1'b0;
    res_beat.last             = 1'b0;
    res_beat.res.servo_id     = id_r;
    res_beat.res.error_bits   = err_r;
    res_beat.res.data_byte    = byte_data;
    res_beat.res.param_index  = count_r;
    res_beat.res.frame_status = ST_GOOD;

    if (take) begin
      unique case (phase_r)
        PH_HUNT1: begin
          phase_nxt = (byte_data == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
        end
        PH_HUNT2: begin
          phase_nxt = (byte_data == HDR_BYTE) ? PH_HDR : PH_HUNT1;
        end
        PH_HDR: begin
          // Extra 0xFF bytes are preamble; hold here.
          if (byte_data != HDR_BYTE) begin
            id_nxt    = byte_data;
            sum_nxt   = byte_data;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          sum_nxt   = sum_r + byte_data;
          short_nxt = (byte_data < MIN_LEN);
          left_nxt  = (byte_data < MIN_LEN) ? 8'd0 : byte_data - MIN_LEN;
          phase_nxt = PH_ERR;
        end
        PH_ERR: begin
          err_nxt   = byte_data;
          sum_nxt   = sum_r + byte_data;
          count_nxt = 8'd0;
          if (left_r == 8'd0) begin
            phase_nxt = short_r ? PH_CHK_SHORT : PH_CHK;
          end else begin
            phase_nxt = PH_PARAM;
          end
        end
        PH_PARAM: begin
          res_valid = 1'b1;
          sum_nxt   = sum_r + byte_data;
          count_nxt = count_r + 8'd1;
          left_nxt  = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = PH_CHK;
          end
        end
        PH_CHK, PH_CHK_SHORT: begin
          res_valid     = 1'b1;
          res_beat.last = 1'b1;
          if (phase_r == PH_CHK_SHORT) begin
            res_beat.res.frame_status = ST_SHORT;
          end else if (byte_data != ~sum_r) begin
            res_beat.res.frame_status = ST_CSUM;
          end
          short_nxt = 1'b0;
          phase_nxt = PH_HUNT1;
        end
        default: begin
          phase_nxt = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      id_r    <= 8'd0;
      err_r   <= 8'd0;
      left_r  <= 8'd0;
      count_r <= 8'd0;
      sum_r   <= 8'd0;
      short_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      err_r   <= err_nxt;
      left_r  <= left_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      short_r <= short_nxt;
    end
  end

endmodule

// ===== src/ssfp_out_reg.sv =====
`timescale 1ns / 1ps

module ssfp_out_reg import ssfp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  input  result_beat_t res_beat,
  output logic         can_take,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,
  output logic         out_tlast
);

  logic         valid_r, valid_nxt;
  result_beat_t beat_r;

  assign can_take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_take) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      beat_r <= res_beat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, beat_r.res};
  assign out_tlast  = beat_r.last;

endmodule

// ===== src/ssfp_checker.sv =====
`timescale 1ns / 1ps
`include "servo_status_frame_parser_macros.svh"

module ssfp_checker import ssfp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  logic [1:0] status;
  logic [7:0] index;

  assign status = out_tdata[33:32];
  assign index  = out_tdata[31:24];

  `SSFP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result beat changed")
  `SSFP_ASSERT_SAME(a_status_on_last, out_tvalid && !out_tlast, status == ST_GOOD, "frame status set on a parameter beat")
  `SSFP_ASSERT_SAME(a_short_no_params, out_tvalid && out_tlast && status == ST_SHORT, index == 8'd0, "short frame reported parameter bytes")
  `SSFP_ASSERT_SAME(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty result register")

endmodule

bind servo_status_frame_parser ssfp_checker u_ssfp_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb import ssfp_pkg::*;;

  // Cycles with no beat on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 1000;
  // Quiet cycles after the last expected beat, as a margin.
  localparam int DRAIN_CYCLES = 20;
  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int MAX_REPORTS  = 40;
  localparam int N_DIRECTED   = 22;

  // One byte to send, and optionally the beat it must produce, typed in by hand.
  // Fields from the top: typed, want, rx.
  typedef struct packed {
    logic         typed;
    result_beat_t want;
    logic [7:0]   rx;
  } byte_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;  // [7:0] servo_id, [15:8] error_bits, [23:16] data_byte,
                           // [31:24] param_index, [33:32] frame_status, rest zero
  logic        out_tlast;

  servo_status_frame_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Directed bytes. Typed rows carry the beat read straight off the frame:
  //   {typed, last, frame_status, param_index, data_byte, error_bits, servo_id, rx}
  byte_row_t directed_tbl [N_DIRECTED] = '{
    // Extra 0xFF before the id is preamble; 0xFF as the error byte is data;
    // the checksum should be 0x00, so 0x01 is a mismatch.
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, 8'hFE},
    {1'b0, 35'd0, 8'h02},
    {1'b0, 35'd0, 8'hFF},
    {1'b1, 1'b1, ST_CSUM, 8'd0, 8'h01, 8'hFF, 8'hFE, 8'h01},
    // A lone 0xFF followed by a non-0xFF byte restarts the hunt.
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, 8'h00},
    // Id zero, length zero: error byte still read, next byte closes as short.
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, 8'h00},
    {1'b0, 35'd0, 8'h00},
    {1'b0, 35'd0, 8'h80},
    {1'b1, 1'b1, ST_SHORT, 8'd0, 8'h33, 8'h80, 8'h00, 8'h33},
    // One parameter byte of 0xFF inside the frame, good checksum 0xED.
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, HDR_BYTE},
    {1'b0, 35'd0, 8'h10},
    {1'b0, 35'd0, 8'h03},
    {1'b0, 35'd0, 8'h00},
    {1'b1, 1'b0, ST_GOOD, 8'd0, 8'hFF, 8'h00, 8'h10, 8'hFF},
    {1'b1, 1'b1, ST_GOOD, 8'd1, 8'hED, 8'h00, 8'h10, 8'hED}
  };

  // Frame decoder state, tracked alongside the block.
  phase_t     rx_phase     = PH_HUNT1;
  logic [7:0] rx_id        = 8'h00;
  logic [7:0] rx_err       = 8'h00;
  logic [7:0] rx_left      = 8'h00;
  logic [7:0] rx_seen      = 8'h00;
  logic [7:0] rx_sum       = 8'h00;
  logic       rx_short     = 1'b0;

  byte_row_t    rows_on_wire [$];
  result_beat_t results_due  [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;
  int stall_cycles  = 0;
  int mismatches    = 0;
  int n_params      = 0;
  int n_good        = 0;
  int n_csum        = 0;
  int n_short       = 0;
  int longest_frame = 0;

  // Advance the frame decoder by one received byte; return the beat it causes.
  task automatic decode_byte(input logic [7:0] b, output logic has_beat,
                             output result_beat_t beat);
    has_beat = 1'b0;
    beat     = '0;
    case (rx_phase)
      PH_HUNT1: rx_phase = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
      PH_HUNT2: rx_phase = (b == HDR_BYTE) ? PH_HDR : PH_HUNT1;
      PH_HDR: begin
        if (b != HDR_BYTE) begin
          rx_id    = b;
          rx_sum   = b;
          rx_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        rx_sum   = rx_sum + b;
        rx_short = (b < MIN_LEN);
        rx_left  = rx_short ? 8'd0 : b - MIN_LEN;
        if (int'(b) > longest_frame) longest_frame = int'(b);
        rx_phase = PH_ERR;
      end
      PH_ERR: begin
        rx_err  = b;
        rx_sum  = rx_sum + b;
        rx_seen = 8'd0;
        if (rx_left == 8'd0) rx_phase = rx_short ? PH_CHK_SHORT : PH_CHK;
        else rx_phase = PH_PARAM;
      end
      PH_PARAM: begin
        has_beat = 1'b1;
        beat     = {1'b0, ST_GOOD, rx_seen, b, rx_err, rx_id};
        rx_sum   = rx_sum + b;
        rx_seen  = rx_seen + 8'd1;
        rx_left  = rx_left - 8'd1;
        if (rx_left == 8'd0) rx_phase = PH_CHK;
      end
      default: begin
        has_beat = 1'b1;
        beat     = {1'b1, ST_GOOD, rx_seen, b, rx_err, rx_id};
        if (rx_phase == PH_CHK_SHORT) beat.res.frame_status = ST_SHORT;
        else if (b != ~rx_sum) beat.res.frame_status = ST_CSUM;
        rx_phase = PH_HUNT1;
        rx_short = 1'b0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
    mismatches++;
  endtask

  // Follow both channels: decode accepted bytes, check accepted result beats.
  always @(posedge clk) begin
    byte_row_t    row;
    logic         has_beat;
    result_beat_t beat;
    result_beat_t want;
    result_t      got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        row = rows_on_wire.pop_front();
        decode_byte(row.rx, has_beat, beat);
        if (has_beat) begin
          // Prefer the hand-typed beat where the table gives one.
          results_due.push_back(row.typed ? row.want : beat);
          if (!beat.last) n_params++;
          else if (beat.res.frame_status == ST_GOOD) n_good++;
          else if (beat.res.frame_status == ST_CSUM) n_csum++;
          else n_short++;
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[33:0];
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing due, data_byte", got.data_byte, 8'h00);
        end else begin
          want = results_due.pop_front();
          if (got.servo_id !== want.res.servo_id)
            report_mismatch("servo_id", got.servo_id, want.res.servo_id);
          if (got.error_bits !== want.res.error_bits)
            report_mismatch("error_bits", got.error_bits, want.res.error_bits);
          if (got.data_byte !== want.res.data_byte)
            report_mismatch("data_byte", got.data_byte, want.res.data_byte);
          if (got.param_index !== want.res.param_index)
            report_mismatch("param_index", got.param_index, want.res.param_index);
          if (got.frame_status !== want.res.frame_status)
            report_mismatch("frame_status", {6'd0, got.frame_status},
                            {6'd0, want.res.frame_status});
          if (out_tlast !== want.last)
            report_mismatch("tlast", {7'd0, out_tlast}, {7'd0, want.last});
          if (out_tdata[39:34] !== 6'd0)
            report_mismatch("tdata pad bits", {2'd0, out_tdata[39:34]}, 8'h00);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Stall the result side at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hang detector: give up once nothing has moved for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("run stalled after %0d bytes", bytes_sent);
    $display("FAIL");
    $finish;
  end

  // Present one byte, idling first at the current rate; hold it until accepted.
  task automatic drive_byte(input byte_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.rx;
    rows_on_wire.push_back(row);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drive_plain(input logic [7:0] b);
    drive_byte({1'b0, 35'd0, b});
  endtask

  // Random byte biased toward 0xFF, so in-frame 0xFF shows up often.
  function automatic logic [7:0] rand_payload();
    return ($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom_range(255));
  endfunction

  // Send one frame; len < 0 picks a length, mostly 2 to 12. With cut set,
  // stop after the error byte so the next bytes land inside the frame.
  task automatic send_frame(input int len, input bit cut);
    logic [7:0] seq [$];
    logic [7:0] sum;
    logic [7:0] id;
    logic [7:0] err;
    logic [7:0] p;
    int         pick;
    pick = $urandom_range(99);
    if (len < 0)
      len = (pick < 8) ? $urandom_range(0, 1) :
            (pick < 90) ? $urandom_range(2, 12) : $urandom_range(13, 40);
    seq.push_back(HDR_BYTE);
    seq.push_back(HDR_BYTE);
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 3)) seq.push_back(HDR_BYTE);
    id  = 8'($urandom_range(0, 254));
    err = 8'($urandom_range(255));
    seq.push_back(id);
    seq.push_back(8'(len));
    seq.push_back(err);
    sum = id + 8'(len) + err;
    if (!cut) begin
      for (int i = 2; i < len; i++) begin
        p = rand_payload();
        sum += p;
        seq.push_back(p);
      end
      // Mostly a good checksum; otherwise any byte.
      seq.push_back(($urandom_range(3) != 0) ? ~sum : 8'($urandom_range(255)));
    end
    foreach (seq[i]) drive_plain(seq[i]);
  endtask

  // One chunk of traffic: mostly well-formed frames, some noise and broken ones.
  task automatic send_random_chunk();
    int kind;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 4)) drive_plain(rand_payload());
    end else if (kind < 16) begin
      drive_plain(HDR_BYTE);
      drive_plain(8'($urandom_range(0, 254)));
    end else if (kind < 21) begin
      send_frame(-1, 1'b1);
    end else begin
      send_frame(-1, 1'b0);
    end
  endtask

  task automatic run_traffic(input int n_bytes, input int send_pct, input int recv_pct);
    int start;
    start         = bytes_sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (bytes_sent - start < n_bytes) send_random_chunk();
  endtask

  initial begin
    // Hold reset first, then release it for the rest of the run.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 60;
    for (int i = 0; i < N_DIRECTED; i++) drive_byte(directed_tbl[i]);

    run_traffic(520, 32, 60);
    run_traffic(520, 60, 32);
    // No idling: longest frame first, then a minimal frame, then random traffic.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_frame(255, 1'b0);
    send_frame(2, 1'b0);
    run_traffic(520, 0, 0);
    in_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes, longest length field %0d, %0d parameter beats",
             bytes_sent, longest_frame, n_params);
    $display("closing beats: %0d good, %0d checksum mismatch, %0d short; %0d mismatches",
             n_good, n_csum, n_short, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
